// ===== hdl/esdk_pkg.sv =====
// ---------------------------------------------------------------------------
// esdk_pkg: shared definitions for the escape sequence key decoder
// Byte codes, key codes and field widths used across the decoder files.
// ---------------------------------------------------------------------------
package esdk_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned KeyW  = 11;

	typedef logic [ByteW-1:0] byte_t;
	typedef logic [KeyW-1:0]  key_t;

	// configuration register indexes
	typedef enum logic {
		CFG_TIMEOUT = 1'b0,
		CFG_WAIT    = 1'b1
	} cfg_idx_t;

	localparam byte_t TimeoutReset = 8'd10;

	// input kinds
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// received byte values
	localparam byte_t CH_BS    = 8'd8;
	localparam byte_t CH_LF    = 8'd10;
	localparam byte_t CH_CR    = 8'd13;
	localparam byte_t CH_ESC   = 8'd27;
	localparam byte_t CH_DEL   = 8'd127;
	localparam byte_t CH_0     = 8'h30;
	localparam byte_t CH_1     = 8'h31;
	localparam byte_t CH_2     = 8'h32;
	localparam byte_t CH_3     = 8'h33;
	localparam byte_t CH_4     = 8'h34;
	localparam byte_t CH_5     = 8'h35;
	localparam byte_t CH_6     = 8'h36;
	localparam byte_t CH_7     = 8'h37;
	localparam byte_t CH_8     = 8'h38;
	localparam byte_t CH_9     = 8'h39;
	localparam byte_t CH_SEMI  = 8'h3B;
	localparam byte_t CH_LBR   = 8'h5B;
	localparam byte_t CH_TILDE = 8'h7E;
	localparam byte_t CH_UA    = 8'h41;
	localparam byte_t CH_UB    = 8'h42;
	localparam byte_t CH_UC    = 8'h43;
	localparam byte_t CH_UD    = 8'h44;
	localparam byte_t CH_UE    = 8'h45;
	localparam byte_t CH_UF    = 8'h46;
	localparam byte_t CH_UH    = 8'h48;
	localparam byte_t CH_UO    = 8'h4F;
	localparam byte_t CH_UP    = 8'h50;
	localparam byte_t CH_UQ    = 8'h51;
	localparam byte_t CH_UR    = 8'h52;
	localparam byte_t CH_US    = 8'h53;
	localparam byte_t CH_LD    = 8'h64;
	localparam byte_t CH_LE    = 8'h65;
	localparam byte_t CH_LF_   = 8'h66;
	localparam byte_t CH_LH    = 8'h68;
	localparam byte_t CH_LS    = 8'h73;
	localparam byte_t CH_LT    = 8'h74;

	// key codes
	localparam key_t K_BS     = 11'd8;
	localparam key_t K_ENTER  = 11'd13;
	localparam key_t K_ESC    = 11'd27;
	localparam key_t K_LEFT   = 11'd1000;
	localparam key_t K_RIGHT  = 11'd1001;
	localparam key_t K_UP     = 11'd1002;
	localparam key_t K_DOWN   = 11'd1003;
	localparam key_t K_DEL    = 11'd1004;
	localparam key_t K_HOME   = 11'd1005;
	localparam key_t K_END    = 11'd1006;
	localparam key_t K_PGUP   = 11'd1007;
	localparam key_t K_PGDN   = 11'd1008;
	localparam key_t K_INS    = 11'd1009;
	localparam key_t K_F1     = 11'd1010;
	localparam key_t K_F2     = 11'd1011;
	localparam key_t K_F3     = 11'd1012;
	localparam key_t K_F4     = 11'd1013;
	localparam key_t K_F5     = 11'd1014;
	localparam key_t K_F10    = 11'd1015;
	localparam key_t K_ALTF   = 11'd1016;
	localparam key_t K_ALTE   = 11'd1017;
	localparam key_t K_ALTS   = 11'd1018;
	localparam key_t K_ALTD   = 11'd1019;
	localparam key_t K_ALTH   = 11'd1020;
	localparam key_t K_SUP    = 11'd1021;
	localparam key_t K_SDOWN  = 11'd1022;
	localparam key_t K_SLEFT  = 11'd1023;
	localparam key_t K_SRIGHT = 11'd1024;
	localparam key_t K_CINS   = 11'd1025;
	localparam key_t K_SDEL   = 11'd1026;
	localparam key_t K_SINS   = 11'd1027;

endpackage

// ===== hdl/esdk_in_if.sv =====
// ---------------------------------------------------------------------------
// esdk_in_if: input channel of the key decoder
// Carries one received byte or one timeout tick per beat.
// ---------------------------------------------------------------------------
interface esdk_in_if;
	import esdk_pkg::*;

	logic  valid;
	logic  ready;
	logic  func;
	byte_t rx_byte;

	modport source (output valid, output func, output rx_byte, input ready);
	modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

// ===== hdl/esdk_out_if.sv =====
// ---------------------------------------------------------------------------
// esdk_out_if: output channel of the key decoder
// Carries one decoded key code per beat.
// ---------------------------------------------------------------------------
interface esdk_out_if;
	import esdk_pkg::*;

	logic valid;
	logic ready;
	key_t key_code;

	modport source (output valid, output key_code, input ready);
	modport sink   (input valid, input key_code, output ready);
endinterface

// ===== hdl/escape_sequence_key_decoder_unit.sv =====
// ---------------------------------------------------------------------------
// escape_sequence_key_decoder_unit: terminal escape sequence key decoder
// Turns terminal bytes and timeout ticks into key codes, parsing ESC, CSI
// and SS3 sequences one byte per beat.
// ---------------------------------------------------------------------------
//  channel   dir  payload               handshake
//  in_ch     in   func, rx_byte         valid/ready
//  key_ch    out  key_code (11 bit)     valid/ready
//  cfg       in   cfg_we/cfg_index/cfg_data, write only
//
//  Two stages: an input register, then the parser step into the key register.
//  One beat per cycle sustained while the key register is free to take keys.
//  The parse state is registered and fed back, so every beat sees the state
//  left by the previous one. Reset clears state and valids and resets the configuration.
//  A stalled key register holds the parser only when a new key is produced.
// ---------------------------------------------------------------------------
module escape_sequence_key_decoder_unit
	import esdk_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	esdk_in_if.sink        in_ch,
	esdk_out_if.source     key_ch,
	input  logic           cfg_we,
	input  cfg_idx_t       cfg_index,
	input  byte_t          cfg_data
);

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_ESC    = 3'd1,
		PH_CSI    = 3'd2,
		PH_CSI_D  = 3'd3,
		PH_SEMI   = 3'd4,
		PH_SEMI2  = 3'd5,
		PH_CSI_DD = 3'd6,
		PH_SS3    = 3'd7
	} phase_t;

	// configuration
	byte_t timeout_q;
	logic  wait_q;

	// input stage
	logic  valid_s1;
	logic  func_s1;
	byte_t byte_s1;

	// parser state
	phase_t phase_q, phase_d;
	byte_t  first_q, first_d;
	byte_t  second_q, second_d;
	byte_t  third_q, third_d;
	byte_t  tick_q, tick_d;
	byte_t  tick_inc;

	// result register
	logic  out_valid_q;
	key_t  key_q;

	logic  fire;
	key_t  key_d;
	logic  out_free;
	logic  advance;

	assign out_free     = !out_valid_q || key_ch.ready;
	assign advance      = valid_s1 && (!fire || out_free);
	assign in_ch.ready  = !valid_s1 || advance;
	assign key_ch.valid = out_valid_q;
	assign key_ch.key_code = key_q;
	assign tick_inc     = (tick_q == 8'hFF) ? tick_q : tick_q + 8'd1;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TimeoutReset;
			wait_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TIMEOUT: timeout_q <= cfg_data;
				CFG_WAIT:    wait_q    <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	// capture input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			func_s1 <= in_ch.func;
			byte_s1 <= in_ch.rx_byte;
		end
	end

	// parser step for the beat in the input stage
	always_comb begin
		phase_d  = phase_q;
		first_d  = first_q;
		second_d = second_q;
		third_d  = third_q;
		tick_d   = tick_q;
		fire     = 1'b0;
		key_d    = K_ESC;
		if (func_s1 == FUNC_TICK) begin
			if (phase_q == PH_ESC && !wait_q) begin
				tick_d = tick_inc;
				if (tick_inc >= timeout_q) begin
					fire    = 1'b1;
					key_d   = K_ESC;
					phase_d = PH_IDLE;
				end
			end
		end else begin
			fire    = 1'b1;
			phase_d = PH_IDLE;
			case (phase_q)
				PH_IDLE: begin
					if (byte_s1 == CH_CR || byte_s1 == CH_LF) begin
						key_d = K_ENTER;
					end else if (byte_s1 == CH_BS || byte_s1 == CH_DEL) begin
						key_d = K_BS;
					end else if (byte_s1 == CH_ESC) begin
						fire    = 1'b0;
						phase_d = PH_ESC;
						tick_d  = '0;
					end else begin
						key_d = {3'b000, byte_s1};
					end
				end
				PH_ESC: begin
					case (byte_s1)
						CH_LF_, CH_UF: key_d = K_ALTF;
						CH_LE,  CH_UE: key_d = K_ALTE;
						CH_LS,  CH_US: key_d = K_ALTS;
						CH_LD,  CH_UD: key_d = K_ALTD;
						CH_LH,  CH_UH: key_d = K_ALTH;
						CH_LBR: begin
							fire    = 1'b0;
							phase_d = PH_CSI;
						end
						CH_UO: begin
							fire    = 1'b0;
							phase_d = PH_SS3;
						end
						default: key_d = K_ESC;
					endcase
				end
				PH_CSI: begin
					if (byte_s1 >= CH_0 && byte_s1 <= CH_9) begin
						fire    = 1'b0;
						first_d = byte_s1;
						phase_d = PH_CSI_D;
					end else begin
						case (byte_s1)
							CH_UA:   key_d = K_UP;
							CH_UB:   key_d = K_DOWN;
							CH_UC:   key_d = K_RIGHT;
							CH_UD:   key_d = K_LEFT;
							CH_UH:   key_d = K_HOME;
							CH_UF:   key_d = K_END;
							default: key_d = K_ESC;
						endcase
					end
				end
				PH_CSI_D: begin
					if (byte_s1 == CH_TILDE) begin
						case (first_q)
							CH_1, CH_7: key_d = K_HOME;
							CH_2:       key_d = K_INS;
							CH_3:       key_d = K_DEL;
							CH_4, CH_8: key_d = K_END;
							CH_5:       key_d = K_PGUP;
							CH_6:       key_d = K_PGDN;
							default:    key_d = K_ESC;
						endcase
					end else if (byte_s1 == CH_SEMI) begin
						fire    = 1'b0;
						phase_d = PH_SEMI;
					end else begin
						fire     = 1'b0;
						second_d = byte_s1;
						phase_d  = PH_CSI_DD;
					end
				end
				PH_SEMI: begin
					fire    = 1'b0;
					third_d = byte_s1;
					phase_d = PH_SEMI2;
				end
				PH_SEMI2: begin
					key_d = K_ESC;
					if (first_q == CH_1 && third_q == CH_2 && byte_s1 == CH_UA) begin
						key_d = K_SUP;
					end else if (first_q == CH_1 && third_q == CH_2 && byte_s1 == CH_UB) begin
						key_d = K_SDOWN;
					end else if (first_q == CH_1 && third_q == CH_2 && byte_s1 == CH_UC) begin
						key_d = K_SRIGHT;
					end else if (first_q == CH_1 && third_q == CH_2 && byte_s1 == CH_UD) begin
						key_d = K_SLEFT;
					end else if (byte_s1 == CH_TILDE) begin
						if (first_q == CH_2 && third_q == CH_5) begin
							key_d = K_CINS;
						end else if (first_q == CH_3 && third_q == CH_2) begin
							key_d = K_SDEL;
						end else if (first_q == CH_2 && third_q == CH_2) begin
							key_d = K_SINS;
						end
					end
				end
				PH_CSI_DD: begin
					key_d = K_ESC;
					if (byte_s1 == CH_TILDE) begin
						if (first_q == CH_2 && second_q == CH_1) begin
							key_d = K_F10;
						end else if (second_q >= CH_1 && second_q <= CH_5) begin
							key_d = K_F1 + {3'b000, second_q - CH_1};
						end
					end
				end
				PH_SS3: begin
					case (byte_s1)
						CH_UH:   key_d = K_HOME;
						CH_UF:   key_d = K_END;
						CH_UP:   key_d = K_F1;
						CH_UQ:   key_d = K_F2;
						CH_UR:   key_d = K_F3;
						CH_US:   key_d = K_F4;
						CH_LT:   key_d = K_F5;
						default: key_d = K_ESC;
					endcase
				end
				default: begin
					fire = 1'b0;
				end
			endcase
		end
	end

	// advance parser state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			first_q     <= '0;
			second_q    <= '0;
			third_q     <= '0;
			tick_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q  <= phase_d;
				first_q  <= first_d;
				second_q <= second_d;
				third_q  <= third_d;
				tick_q   <= tick_d;
			end
			if (out_free) begin
				out_valid_q <= advance && fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire) begin
			key_q <= key_d;
		end
	end

	// checks
	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (key_q <= K_SINS))
		else $error("key code out of range");

	a_plain_byte_fires: assert property (@(posedge clk) disable iff (!arst_n)
		advance && func_s1 == FUNC_BYTE && phase_q == PH_IDLE && byte_s1 != CH_ESC
		|=> out_valid_q)
		else $error("plain byte produced no key");

	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> valid_s1 && fire && !out_free)
		else $error("input stalled without a blocked key");

	a_digit_param: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CSI_D || phase_q == PH_SEMI || phase_q == PH_SEMI2
			|| phase_q == PH_CSI_DD) |-> (first_q >= CH_0 && first_q <= CH_9))
		else $error("first parameter is not a digit");

	a_tick_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		advance && func_s1 == FUNC_TICK && phase_q != PH_ESC |-> !fire)
		else $error("tick outside ESC produced a key");

endmodule

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb: self-checking bench for the escape sequence key decoder
// Streams terminal bytes and timeout ticks into the decoder and predicts
// every key code with its own parser copy. Each key is checked against the
// oldest prediction. Runs a directed opening, then randomized sequences
// under several timeout settings with random stalls on both channels.
// ---------------------------------------------------------------------------
module tb;
	import esdk_pkg::*;

	localparam int unsigned SettleCycles = 8;
	localparam int unsigned EndCycles    = 10;
	localparam int unsigned LongHold     = 150;
	localparam int unsigned TimeLimit    = 2_000_000;

	// parser phases of the predictor
	typedef enum logic [2:0] {
		PS_IDLE,
		PS_ESC,
		PS_CSI,
		PS_CSI_NUM,
		PS_SEMI,
		PS_SEMI_ARG,
		PS_CSI_NUM2,
		PS_SS3
	} parse_st_t;

	typedef struct packed {
		logic  func;
		byte_t data;
	} term_beat_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	byte_t cfg_data;

	esdk_in_if  in_ch ();
	esdk_out_if key_ch ();

	escape_sequence_key_decoder_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.key_ch    (key_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state and configuration
	parse_st_t dec_state = PS_IDLE;
	byte_t csi_arg   = '0;
	byte_t csi_arg2  = '0;
	byte_t chord_arg = '0;
	byte_t esc_ticks = '0;
	byte_t timeout_cfg = TimeoutReset;
	logic  wait_cfg    = 1'b0;

	term_beat_t pending_beats [$];
	key_t expected_keys [$];

	int unsigned src_gap_max  = 0;
	int unsigned sink_gap_max = 0;
	int unsigned src_wait;
	int unsigned sink_wait;
	int unsigned sink_draw;
	int unsigned hold_left;
	int unsigned beats_queued   = 0;
	int unsigned beats_accepted = 0;
	int unsigned ticks_accepted = 0;
	int unsigned keys_checked   = 0;
	int unsigned settings_used  = 1;
	int unsigned error_count    = 0;
	term_beat_t next_beat;
	key_t pred_key;
	key_t want_key;
	bit got_key;

	task automatic flag_error(input string msg);
		$display("ERROR %0t: %s", $time, msg);
		error_count++;
	endtask

	// Advance the parser by one beat; return 1 when a key comes out.
	function automatic bit decode_beat(input logic fn, input byte_t b, output key_t key);
		bit hit;
		bit shift_form;
		parse_st_t nxt;
		hit = 1'b1;
		nxt = PS_IDLE;
		key = K_ESC;
		if (fn == FUNC_TICK) begin
			if (dec_state != PS_ESC || wait_cfg)
				return 1'b0;
			if (esc_ticks != 8'hFF)
				esc_ticks++;
			if (esc_ticks >= timeout_cfg) begin
				dec_state = PS_IDLE;
				return 1'b1;
			end
			return 1'b0;
		end
		case (dec_state)
			PS_IDLE: begin
				if (b == CH_CR || b == CH_LF)
					key = K_ENTER;
				else if (b == CH_BS || b == CH_DEL)
					key = K_BS;
				else if (b == CH_ESC) begin
					hit = 1'b0;
					nxt = PS_ESC;
					esc_ticks = '0;
				end else
					key = key_t'(b);
			end
			PS_ESC: begin
				case (b)
					CH_LF_, CH_UF: key = K_ALTF;
					CH_LE, CH_UE:  key = K_ALTE;
					CH_LS, CH_US:  key = K_ALTS;
					CH_LD, CH_UD:  key = K_ALTD;
					CH_LH, CH_UH:  key = K_ALTH;
					CH_LBR: begin
						hit = 1'b0;
						nxt = PS_CSI;
					end
					CH_UO: begin
						hit = 1'b0;
						nxt = PS_SS3;
					end
					default: key = K_ESC;
				endcase
			end
			PS_CSI: begin
				if (b >= CH_0 && b <= CH_9) begin
					csi_arg = b;
					hit = 1'b0;
					nxt = PS_CSI_NUM;
				end else begin
					case (b)
						CH_UA:   key = K_UP;
						CH_UB:   key = K_DOWN;
						CH_UC:   key = K_RIGHT;
						CH_UD:   key = K_LEFT;
						CH_UH:   key = K_HOME;
						CH_UF:   key = K_END;
						default: key = K_ESC;
					endcase
				end
			end
			PS_CSI_NUM: begin
				if (b == CH_TILDE) begin
					case (csi_arg)
						CH_1, CH_7: key = K_HOME;
						CH_2:       key = K_INS;
						CH_3:       key = K_DEL;
						CH_4, CH_8: key = K_END;
						CH_5:       key = K_PGUP;
						CH_6:       key = K_PGDN;
						default:    key = K_ESC;
					endcase
				end else if (b == CH_SEMI) begin
					hit = 1'b0;
					nxt = PS_SEMI;
				end else begin
					csi_arg2 = b;
					hit = 1'b0;
					nxt = PS_CSI_NUM2;
				end
			end
			PS_SEMI: begin
				chord_arg = b;
				hit = 1'b0;
				nxt = PS_SEMI_ARG;
			end
			PS_SEMI_ARG: begin
				shift_form = (csi_arg == CH_1 && chord_arg == CH_2);
				if (shift_form && b == CH_UA)
					key = K_SUP;
				else if (shift_form && b == CH_UB)
					key = K_SDOWN;
				else if (shift_form && b == CH_UC)
					key = K_SRIGHT;
				else if (shift_form && b == CH_UD)
					key = K_SLEFT;
				else if (b == CH_TILDE && csi_arg == CH_2 && chord_arg == CH_5)
					key = K_CINS;
				else if (b == CH_TILDE && csi_arg == CH_3 && chord_arg == CH_2)
					key = K_SDEL;
				else if (b == CH_TILDE && csi_arg == CH_2 && chord_arg == CH_2)
					key = K_SINS;
			end
			PS_CSI_NUM2: begin
				if (b == CH_TILDE && csi_arg == CH_2 && csi_arg2 == CH_1)
					key = K_F10;
				else if (b == CH_TILDE && csi_arg2 >= CH_1 && csi_arg2 <= CH_5)
					key = K_F1 + key_t'(csi_arg2 - CH_1);
			end
			PS_SS3: begin
				case (b)
					CH_UH:   key = K_HOME;
					CH_UF:   key = K_END;
					CH_UP:   key = K_F1;
					CH_UQ:   key = K_F2;
					CH_UR:   key = K_F3;
					CH_US:   key = K_F4;
					CH_LT:   key = K_F5;
					default: key = K_ESC;
				endcase
			end
			default: hit = 1'b0;
		endcase
		dec_state = nxt;
		return hit;
	endfunction

	// stimulus helpers
	function automatic byte_t any_byte();
		return byte_t'($urandom_range(0, 255));
	endfunction

	function automatic void push_byte(input byte_t b);
		pending_beats.push_back('{func: FUNC_BYTE, data: b});
		beats_queued++;
	endfunction

	// tick beats carry random filler so every data bit toggles
	function automatic void push_tick();
		pending_beats.push_back('{func: FUNC_TICK, data: any_byte()});
		beats_queued++;
	endfunction

	// occasionally slip a tick in before a sequence byte
	function automatic void seq_byte(input byte_t b);
		if ($urandom_range(0, 9) == 0)
			push_tick();
		push_byte(b);
	endfunction

	// occasionally corrupt a sequence byte
	function automatic byte_t garble(input byte_t b);
		return ($urandom_range(0, 9) == 0) ? any_byte() : b;
	endfunction

	function automatic byte_t alt_letter();
		case ($urandom_range(0, 9))
			0: return CH_LF_;
			1: return CH_UF;
			2: return CH_LE;
			3: return CH_UE;
			4: return CH_LS;
			5: return CH_US;
			6: return CH_LD;
			7: return CH_UD;
			8: return CH_LH;
			default: return CH_UH;
		endcase
	endfunction

	function automatic byte_t csi_final();
		case ($urandom_range(0, 5))
			0: return CH_UA;
			1: return CH_UB;
			2: return CH_UC;
			3: return CH_UD;
			4: return CH_UH;
			default: return CH_UF;
		endcase
	endfunction

	function automatic byte_t ss3_final();
		case ($urandom_range(0, 6))
			0: return CH_UH;
			1: return CH_UF;
			2: return CH_UP;
			3: return CH_UQ;
			4: return CH_UR;
			5: return CH_US;
			default: return CH_LT;
		endcase
	endfunction

	function automatic byte_t any_digit();
		return CH_0 + byte_t'($urandom_range(0, 9));
	endfunction

	function automatic byte_t low_digit();
		return CH_1 + byte_t'($urandom_range(0, 4));
	endfunction

	// Queue one sequence: mostly well-formed with random content, some noise.
	function automatic void push_random_sequence();
		int unsigned kind;
		int unsigned n;
		kind = $urandom_range(0, 99);
		if (kind < 20) begin
			push_byte(any_byte());
			return;
		end
		if (kind < 28) begin
			push_tick();
			return;
		end
		push_byte(CH_ESC);
		if (kind < 36)
			seq_byte(garble(alt_letter()));
		else if (kind < 46) begin
			n = $urandom_range(0, 24);
			repeat (n) push_tick();
		end else if (kind < 56) begin
			seq_byte(garble(CH_LBR));
			seq_byte(garble(csi_final()));
		end else if (kind < 66) begin
			seq_byte(garble(CH_LBR));
			seq_byte(garble(any_digit()));
			seq_byte(garble(CH_TILDE));
		end else if (kind < 76) begin
			seq_byte(garble(CH_LBR));
			seq_byte(garble(low_digit()));
			seq_byte(garble(CH_SEMI));
			seq_byte(garble(low_digit()));
			seq_byte(garble($urandom_range(0, 1) ? CH_TILDE : csi_final()));
		end else if (kind < 86) begin
			seq_byte(garble(CH_LBR));
			seq_byte(garble(low_digit()));
			seq_byte(garble(any_digit()));
			seq_byte(garble(CH_TILDE));
		end else if (kind < 96) begin
			seq_byte(garble(CH_UO));
			seq_byte(garble(ss3_final()));
		end else
			seq_byte(any_byte());
	endfunction

	task automatic queue_random(input int unsigned n);
		int unsigned target;
		target = beats_queued + n;
		while (beats_queued < target)
			push_random_sequence();
	endtask

	// Wait until every beat is taken and every key is back, then let the
	// pipeline empty out in case a sequence is still open.
	task automatic drain();
		while (pending_beats.size() != 0 || in_ch.valid || expected_keys.size() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input byte_t val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == CFG_TIMEOUT)
			timeout_cfg = val;
		else
			wait_cfg = val[0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input byte_t tmo, input logic wf);
		write_reg(CFG_TIMEOUT, tmo);
		write_reg(CFG_WAIT, {7'd0, wf});
		settings_used++;
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#(TimeLimit);
		$display("Test completed with failures");
		$finish;
	end

	// Drive input beats from the pending queue; predict at acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid   <= 1'b0;
			in_ch.func    <= FUNC_BYTE;
			in_ch.rx_byte <= '0;
			src_wait      <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				beats_accepted++;
				if (in_ch.func == FUNC_TICK)
					ticks_accepted++;
				if (decode_beat(in_ch.func, in_ch.rx_byte, pred_key))
					expected_keys.push_back(pred_key);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (src_wait != 0) begin
					in_ch.valid <= 1'b0;
					src_wait    <= src_wait - 1;
				end else if (pending_beats.size() != 0) begin
					next_beat = pending_beats.pop_front();
					in_ch.valid   <= 1'b1;
					in_ch.func    <= next_beat.func;
					in_ch.rx_byte <= next_beat.data;
					src_wait      <= $urandom_range(0, src_gap_max);
				end else
					in_ch.valid <= 1'b0;
			end
		end
	end

	// Take key beats, check them, and stall the key channel at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_ch.ready <= 1'b0;
			sink_wait    <= 0;
			hold_left    <= 0;
		end else begin
			got_key = key_ch.valid && key_ch.ready;
			if (got_key) begin
				keys_checked++;
				if (expected_keys.size() == 0)
					flag_error($sformatf("key %0d arrived with none predicted",
						key_ch.key_code));
				else begin
					want_key = expected_keys.pop_front();
					if (key_ch.key_code !== want_key)
						flag_error($sformatf("key_code %0d, predicted %0d",
							key_ch.key_code, want_key));
				end
			end
			// hold off for a long stretch twice so the decoder backs up
			if (got_key && (keys_checked == 150 || keys_checked == 800)) begin
				hold_left    <= LongHold;
				key_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left    <= hold_left - 1;
				key_ch.ready <= (hold_left == 1);
			end else if (got_key) begin
				sink_draw = $urandom_range(0, sink_gap_max);
				sink_wait    <= sink_draw;
				key_ch.ready <= (sink_draw == 0);
			end else if (sink_wait != 0) begin
				sink_wait    <= sink_wait - 1;
				key_ch.ready <= (sink_wait == 1);
			end else
				key_ch.ready <= 1'b1;
		end
	end

	// stimulus and phase control
	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_TIMEOUT;
		cfg_data      = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed opening with reset configuration
		src_gap_max  = 3;
		sink_gap_max = 3;
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_byte(CH_BS);
		push_byte(CH_DEL);
		push_tick();
		push_byte(CH_ESC);
		push_byte(CH_LF_);
		push_byte(CH_ESC);
		push_byte(CH_LBR);
		push_byte(CH_2);
		push_byte(CH_1);
		push_byte(CH_TILDE);
		push_byte(CH_ESC);
		push_byte(CH_LBR);
		push_byte(CH_1);
		push_byte(CH_SEMI);
		push_byte(CH_2);
		push_byte(CH_UC);
		push_byte(CH_ESC);
		push_byte(8'h00);
		push_byte(CH_ESC);
		push_byte(CH_UO);
		push_byte(CH_LT);
		drain();

		// zero timeout: first tick after ESC reports Escape
		set_config(8'd0, 1'b0);
		src_gap_max  = 11;
		sink_gap_max = 11;
		push_byte(CH_ESC);
		push_tick();
		queue_random(200);
		drain();

		// longest timeout, no idling on either side
		set_config(8'd255, 1'b0);
		src_gap_max  = 0;
		sink_gap_max = 0;
		push_byte(CH_ESC);
		repeat (255) push_tick();
		queue_random(150);
		drain();

		// wait for the next byte forever; ticks after ESC do nothing
		set_config(8'd3, 1'b1);
		src_gap_max  = 11;
		sink_gap_max = 0;
		push_byte(CH_ESC);
		push_tick();
		push_tick();
		push_tick();
		push_tick();
		push_byte(CH_LBR);
		push_byte(CH_UA);
		queue_random(250);
		drain();

		// short random timeouts with the key side stalling, then both sides
		set_config(byte_t'($urandom_range(1, 20)), 1'b0);
		src_gap_max  = 0;
		sink_gap_max = 11;
		queue_random(200);
		drain();

		set_config(byte_t'($urandom_range(1, 20)), 1'b0);
		src_gap_max  = 11;
		sink_gap_max = 11;
		queue_random(200);
		drain();

		repeat (EndCycles) @(posedge clk);
		if (expected_keys.size() != 0)
			flag_error($sformatf("%0d predicted keys never arrived", expected_keys.size()));
		$display("Run covered %0d input beats (%0d ticks) under %0d register settings,",
			beats_accepted, ticks_accepted, settings_used);
		$display("with %0d key codes checked and %0d mismatches.", keys_checked, error_count);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
